// ===== sv/bdq_pkg.sv =====
// Shared constants, widths and encodings for the bounded deque.
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [DATA_W-1:0]  data_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_BACK  = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_LIST      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

endpackage

// ===== sv/bounded_deque_with_value_delete.sv =====
// Bounded deque in a ring store, with remove-by-value and listing.
// Inserts and the empty cases give their result in the cycle after acceptance. Remove
// reads and compares the entries in order, shifts the later entries down by a read and a
// write each, and gives one result, found or not; list gives one result per entry, in order.
// One transaction at a time, as the sequencer steps through the store entry by entry; reset
// clears the front index, the count, the sequencer and the result strobe only.
module bounded_deque_with_value_delete (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bdq_pkg::OP_W-1:0]     operation,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    output logic                         strobe,
    output logic [bdq_pkg::STATUS_W-1:0] status,
    output logic [bdq_pkg::POS_W-1:0]    position,
    output logic signed [bdq_pkg::DATA_W-1:0] entry_value,
    output logic                         last
);
    import bdq_pkg::*;

    state_t  state_reg, state_next;
    idx_t    front_reg, front_next;
    count_t  count_reg, count_next;
    count_t  idx_reg, idx_next;
    data_t   value_reg, value_next;

    logic    strobe_reg, strobe_next;
    status_t status_reg, status_next;
    logic [POS_W-1:0] position_reg, position_next;
    data_t   entry_value_reg, entry_value_next;
    logic    last_reg, last_next;

    data_t   entry_store_mem [CAPACITY];
    data_t   rd_data_reg;
    logic    mem_we;
    idx_t    mem_waddr;
    idx_t    mem_raddr;
    data_t   mem_wdata;

    // Shared slot unit: maps a list offset to a ring index.
    idx_t             slot_offset;
    idx_t             slot_index;
    logic [IDX_W:0]   slot_sum;
    count_t           idx_inc;
    count_t           idx_inc2;
    logic             is_full;
    logic             is_empty;
    logic             match;

    assign idx_inc  = idx_reg + count_t'(1);
    assign idx_inc2 = idx_reg + count_t'(2);
    assign is_full  = (count_reg == count_t'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign match    = (rd_data_reg == value_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:     slot_offset = count_reg[IDX_W-1:0];
            S_SHIFT_RD: slot_offset = idx_inc[IDX_W-1:0];
            default:    slot_offset = idx_reg[IDX_W-1:0];
        endcase
        slot_sum = (IDX_W+1)'(front_reg) + (IDX_W+1)'(slot_offset);
        if (slot_sum >= (IDX_W+1)'(CAPACITY))
        begin
            slot_sum = slot_sum - (IDX_W+1)'(CAPACITY);
        end
        slot_index = slot_sum[IDX_W-1:0];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_REMOVE && !is_empty)
                    begin
                        state_next = S_SEARCH_RD;
                    end
                    else if (operation == OP_LIST && !is_empty)
                    begin
                        state_next = S_LIST_RD;
                    end
                end
            end
            S_SEARCH_RD:  state_next = S_SEARCH_CMP;
            S_SEARCH_CMP:
            begin
                if (match)
                begin
                    state_next = (idx_inc < count_reg) ? S_SHIFT_RD : S_IDLE;
                end
                else
                begin
                    state_next = (idx_inc == count_reg) ? S_IDLE : S_SEARCH_RD;
                end
            end
            S_SHIFT_RD:   state_next = S_SHIFT_WR;
            S_SHIFT_WR:   state_next = (idx_inc2 < count_reg) ? S_SHIFT_RD : S_IDLE;
            S_LIST_RD:    state_next = S_LIST_OUT;
            S_LIST_OUT:   state_next = (idx_inc == count_reg) ? S_IDLE : S_LIST_RD;
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath, store control and result logic.
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        value_next       = value_reg;
        strobe_next      = 1'b0;
        status_next      = status_reg;
        position_next    = position_reg;
        entry_value_next = entry_value_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_waddr        = slot_index;
        mem_wdata        = value;
        mem_raddr        = slot_index;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next       = value;
                    idx_next         = '0;
                    position_next    = '0;
                    last_next        = 1'b1;
                    entry_value_next = value;
                    case (op_t'(operation))
                        OP_INS_FRONT, OP_INS_BACK:
                        begin
                            strobe_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg + count_t'(1);
                                mem_we      = 1'b1;
                                if (operation == OP_INS_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? idx_t'(CAPACITY - 1)
                                                                   : front_reg - idx_t'(1);
                                    mem_waddr  = front_next;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                strobe_next      = 1'b1;
                                status_next      = STAT_EMPTY;
                                entry_value_next = '0;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SEARCH_CMP:
            begin
                if (match)
                begin
                    if (!(idx_inc < count_reg))
                    begin
                        // The match is the final entry, so nothing has to move.
                        count_next       = count_reg - count_t'(1);
                        strobe_next      = 1'b1;
                        status_next      = STAT_OK;
                        entry_value_next = value_reg;
                        last_next        = 1'b1;
                        position_next    = '0;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    strobe_next      = 1'b1;
                    status_next      = STAT_NOT_FOUND;
                    entry_value_next = value_reg;
                    last_next        = 1'b1;
                    position_next    = '0;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                idx_next  = idx_inc;
                if (!(idx_inc2 < count_reg))
                begin
                    count_next       = count_reg - count_t'(1);
                    strobe_next      = 1'b1;
                    status_next      = STAT_OK;
                    entry_value_next = value_reg;
                    last_next        = 1'b1;
                    position_next    = '0;
                end
            end
            S_LIST_OUT:
            begin
                strobe_next      = 1'b1;
                status_next      = STAT_OK;
                position_next    = POS_W'(idx_inc);
                entry_value_next = rd_data_reg;
                last_next        = (idx_inc == count_reg);
                idx_next         = idx_inc;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        status_reg      <= status_next;
        position_reg    <= position_next;
        entry_value_reg <= entry_value_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_store_mem[mem_raddr];
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final result issued while sequencer still busy");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("intermediate result issued with sequencer idle");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && position != '0 |-> status == STAT_OK)
        else $error("listed position carried with a failure status");

endmodule
